FILE: rtl/core/xrng_pkg.sv
// Shared types, constants and the Xorshift128 step for the bounded RNG.
// No dependencies; used by xrng_divider and the top level under rtl/core.
`default_nettype none

package xrng_pkg;

   // Generator words and mixing constants
   localparam int unsigned WORD_W    = 32;
   localparam logic [31:0] SEED_XOR  = 32'hDEAD_BEEF;
   localparam logic [31:0] MIX_MUL   = 32'h41C6_4E6D;
   localparam logic [31:0] MIX_ADD   = 32'h0000_3039;
   localparam int unsigned SHIFT_A   = 11;
   localparam int unsigned SHIFT_B   = 19;
   localparam int unsigned SHIFT_C   = 8;

   // Warm-up after seeding
   localparam int unsigned WARM_STEPS = 16;
   localparam int unsigned WARM_CNT_W = $clog2(WARM_STEPS);

   // Mixing sequence: three multiply-add steps
   localparam int unsigned MIX_STEPS = 3;
   localparam int unsigned MIX_IDX_W = $clog2(MIX_STEPS);

   // Remainder unit: one quotient bit per cycle
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Request commands
   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_DRAW   = 1'b1;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } xs_words_type;

   // Status from the remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b000_0001,
      ST_MIX    = 7'b000_0010,
      ST_WARM   = 7'b000_0100,
      ST_LIMIT  = 7'b000_1000,
      ST_STEP   = 7'b001_0000,
      ST_MODULO = 7'b010_0000,
      ST_DONE   = 7'b100_0000
   } state_type;

   // One Xorshift128 step
   function automatic xs_words_type xs_advance(input xs_words_type cur);
      logic [31:0]  t;
      xs_words_type nxt;
      t     = cur.x ^ (cur.x << SHIFT_A);
      nxt.x = cur.y;
      nxt.y = cur.z;
      nxt.z = cur.w;
      nxt.w = cur.w ^ (cur.w >> SHIFT_B) ^ (t ^ (t >> SHIFT_C));
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xrng_divider.sv
// Iterative restoring divider that yields the 32-bit remainder, one bit a cycle.
// Depends on xrng_pkg.
`default_nettype none

module xrng_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             dividend,
   input  logic [31:0]             divisor,
   output xrng_pkg::div_status_type status,
   output logic [31:0]             remainder
);

   logic [31:0]                    rem_ff, rem_in;
   logic [31:0]                    dvd_ff, dvd_in;
   logic [31:0]                    dvs_ff, dvs_in;
   logic [xrng_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [33:0]                    trial;

   // Trial subtract of the divisor from the shifted partial remainder
   assign trial = {1'b0, rem_ff, dvd_ff[31]} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = xrng_pkg::DIV_CNT_W'(xrng_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restore when the trial borrows
         if (!trial[33]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = {rem_ff[30:0], dvd_ff[31]};
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - xrng_pkg::DIV_CNT_W'(1);
         if (cnt_ff == xrng_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/core/xorshift128_bounded_integer_rng.sv
// Top level of the Xorshift128 bounded-integer generator: sequencer, words, output.
// Depends on xrng_pkg and xrng_divider.
//
// Usage:
//   Request channel (req_*): command 0 reseeds from req_seed_value and gives no
//   result; command 1 draws one integer in [req_lower_bound, req_upper_bound].
//   Response channel (rsp_*): one rsp_random_value transfer per draw.
//   One request is worked on at a time; req_stall stays high until it is done.
// Work per request:
//   reseed: three multiply-add steps on the one multiplier, then 16 warm-up
//     steps of the generator.
//   draw, lower >= upper: result is the lower bound, generator not advanced.
//   draw over the full 32-bit range: one generator step, no remainder pass.
//   other draws: the remainder unit runs twice, once for the rejection limit
//     and once for the final modulo, plus one more generator step for each
//     rejected value.
// Reset: synchronous; afterwards the block seeds itself with zero, with req_stall
//   high, then waits for requests.
// Stall: a finished result sits in the output register while rsp_stall is high;
//   the next request is taken meanwhile, and its result waits until the register
//   frees.
`default_nettype none

module xorshift128_bounded_integer_rng (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic        [31:0] req_seed_value,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_random_value
);

   xrng_pkg::state_type            state_ff, state_in;
   xrng_pkg::xs_words_type         words_ff, words_in;
   xrng_pkg::xs_words_type         words_next;
   logic [31:0]                    prod_ff, prod_in;
   logic [xrng_pkg::MIX_IDX_W-1:0] mix_idx_ff, mix_idx_in;
   logic                           mix_phase_ff, mix_phase_in;
   logic [xrng_pkg::WARM_CNT_W-1:0] warm_cnt_ff, warm_cnt_in;
   logic [31:0]                    lo_ff, lo_in;
   logic [31:0]                    size_ff, size_in;
   logic                           full_ff, full_in;
   logic [31:0]                    limit_ff, limit_in;
   logic [31:0]                    res_ff, res_in;
   logic [31:0]                    out_ff, out_in;
   logic                           out_valid_ff, out_valid_in;

   logic                           accept;
   logic                           empty_range;
   logic [31:0]                    size_now;
   logic [31:0]                    mul_op;
   logic                           div_start;
   logic [31:0]                    div_dividend;
   logic [31:0]                    div_divisor;
   logic [31:0]                    div_rem;
   xrng_pkg::div_status_type       div_status;

   // Request handshake
   assign req_stall = (state_ff != xrng_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Range decode
   assign empty_range = (req_lower_bound >= req_upper_bound);
   assign size_now    = 32'($unsigned(req_upper_bound) - $unsigned(req_lower_bound) + 32'd1);

   // Generator step
   assign words_next = xrng_pkg::xs_advance(words_ff);

   // Multiplier operand for the three mixing steps; words_ff.x holds the seed here
   always_comb begin
      case (mix_idx_ff)
         2'd0:    mul_op = words_ff.x ^ xrng_pkg::SEED_XOR;
         2'd1:    mul_op = words_ff.y ^ (words_ff.x >> 16);
         default: mul_op = words_ff.z ^ (words_ff.x << 16);
      endcase
   end

   // Remainder unit: limit pass starts at accept, modulo pass on an accepted value
   assign div_start = (accept && (req_command == xrng_pkg::CMD_DRAW) && !empty_range &&
                       (size_now != 32'd0)) ||
                      ((state_ff == xrng_pkg::ST_STEP) && !full_ff &&
                       (words_next.w < limit_ff));
   assign div_dividend = (state_ff == xrng_pkg::ST_IDLE) ? 32'hFFFF_FFFF : words_next.w;
   assign div_divisor  = (state_ff == xrng_pkg::ST_IDLE) ? size_now : size_ff;

   xrng_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .remainder (div_rem)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      words_in     = words_ff;
      prod_in      = prod_ff;
      mix_idx_in   = mix_idx_ff;
      mix_phase_in = mix_phase_ff;
      warm_cnt_in  = warm_cnt_ff;
      lo_in        = lo_ff;
      size_in      = size_ff;
      full_in      = full_ff;
      limit_in     = limit_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      // output register drains on a transfer
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         xrng_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == xrng_pkg::CMD_RESEED) begin
                  words_in.x   = req_seed_value;
                  mix_idx_in   = '0;
                  mix_phase_in = 1'b0;
                  state_in     = xrng_pkg::ST_MIX;
               end else begin
                  lo_in = $unsigned(req_lower_bound);
                  if (empty_range) begin
                     res_in   = $unsigned(req_lower_bound);
                     state_in = xrng_pkg::ST_DONE;
                  end else begin
                     size_in  = size_now;
                     full_in  = (size_now == 32'd0);
                     state_in = (size_now == 32'd0) ? xrng_pkg::ST_STEP : xrng_pkg::ST_LIMIT;
                  end
               end
            end
         end
         xrng_pkg::ST_MIX: begin
            // phase 0 multiplies, phase 1 adds and writes the word
            if (!mix_phase_ff) begin
               prod_in      = mul_op * xrng_pkg::MIX_MUL;
               mix_phase_in = 1'b1;
            end else begin
               mix_phase_in = 1'b0;
               case (mix_idx_ff)
                  2'd0:    words_in.y = prod_ff + xrng_pkg::MIX_ADD;
                  2'd1:    words_in.z = prod_ff + xrng_pkg::MIX_ADD;
                  default: words_in.w = prod_ff + xrng_pkg::MIX_ADD;
               endcase
               if (mix_idx_ff == xrng_pkg::MIX_IDX_W'(xrng_pkg::MIX_STEPS - 1)) begin
                  warm_cnt_in = '0;
                  state_in    = xrng_pkg::ST_WARM;
               end else begin
                  mix_idx_in = mix_idx_ff + xrng_pkg::MIX_IDX_W'(1);
               end
            end
         end
         xrng_pkg::ST_WARM: begin
            words_in    = words_next;
            warm_cnt_in = warm_cnt_ff + xrng_pkg::WARM_CNT_W'(1);
            if (warm_cnt_ff == xrng_pkg::WARM_CNT_W'(xrng_pkg::WARM_STEPS - 1)) begin
               state_in = xrng_pkg::ST_IDLE;
            end
         end
         xrng_pkg::ST_LIMIT: begin
            // largest multiple of size is all-ones minus (all-ones mod size)
            if (div_status.done) begin
               limit_in = ~div_rem;
               state_in = xrng_pkg::ST_STEP;
            end
         end
         xrng_pkg::ST_STEP: begin
            words_in = words_next;
            if (full_ff) begin
               res_in   = words_next.w;
               state_in = xrng_pkg::ST_DONE;
            end else if (words_next.w < limit_ff) begin
               state_in = xrng_pkg::ST_MODULO;
            end
         end
         xrng_pkg::ST_MODULO: begin
            if (div_status.done) begin
               res_in   = lo_ff + div_rem;
               state_in = xrng_pkg::ST_DONE;
            end
         end
         xrng_pkg::ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = xrng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xrng_pkg::ST_IDLE;
         end
      endcase
   end

   // Registers; reset starts a reseed with zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrng_pkg::ST_MIX;
         mix_idx_ff   <= '0;
         mix_phase_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         words_ff.x   <= '0;
      end else begin
         state_ff     <= state_in;
         mix_idx_ff   <= mix_idx_in;
         mix_phase_ff <= mix_phase_in;
         out_valid_ff <= out_valid_in;
         words_ff     <= words_in;
      end
      prod_ff     <= prod_in;
      warm_cnt_ff <= warm_cnt_in;
      lo_ff       <= lo_in;
      size_ff     <= size_in;
      full_ff     <= full_in;
      limit_ff    <= limit_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_random_value = $signed(out_ff);

endmodule

`default_nettype wire

FILE: rtl/core/xrng_checker.sv
// Port-level checks for the bounded RNG, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module xrng_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_command,
   input logic signed [31:0] req_lower_bound,
   input logic signed [31:0] req_upper_bound,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_random_value
);

   // Self-seeding after reset keeps requests out
   a_reset_seeds: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during post-reset seeding");

   // One request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted back to back");

   // A reseed never produces a result
   a_reseed_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_command) |=> !$rose(rsp_valid))
      else $error("result appeared after a reseed");

   // When the output is free, an empty or single range returns the lower bound
   a_empty_range: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command && !rsp_valid &&
       (req_lower_bound >= req_upper_bound))
      |-> ##2 (rsp_valid && (rsp_random_value == $past(req_lower_bound, 2))))
      else $error("empty range did not return the lower bound");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_random_value)))
      else $error("stalled result changed");

endmodule

bind xorshift128_bounded_integer_rng xrng_checker u_xrng_checker (.*);

`default_nettype wire
